/* sv/asc_pkg.sv */
// Shared types and constants of the ADC sample conditioner.
package asc_pkg;

    // Width of a conditioned value and of the segment arithmetic; the slope product is twice as wide
    localparam int VAL_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_ENABLE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_WEIGHT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINEAR_ENABLE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINEARIZE_FIRST = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT     = 3'd4;

    localparam int WEIGHT_W = 4;
    localparam int COUNT_W  = 5;

    // Item kinds carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POINT  = 1'b1;

    // Filter: weights are tenths; divide the weighted sum by ten with a reciprocal
    localparam logic [WEIGHT_W-1:0] FILT_DEN = 4'd10;
    localparam int FILT_SUM_W  = 20;
    localparam int FILT_PROD_W = 40;
    localparam int FILT_SHIFT  = 23;
    localparam logic [FILT_SUM_W-1:0] FILT_RECIP = 20'd838861;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* sv/asc_div.sv */
// Iterative restoring divider for the calibration slope, one quotient bit a cycle.
module asc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  asc_pkg::div_req_t req,
    output asc_pkg::div_rsp_t rsp
);
    localparam int VW = asc_pkg::VAL_W;
    localparam int CW = $clog2(VW);

    logic [VW-1:0] rem_reg;
    logic [VW-1:0] quo_reg;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   shift_next;
    logic [VW:0]   diff_next;
    logic [VW-1:0] rem_next;
    logic [VW-1:0] quo_next;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        shift_next = {rem_reg, quo_reg[VW-1]};
        diff_next  = shift_next - {1'b0, dsr_reg};
        if (diff_next[VW]) begin
            rem_next = shift_next[VW-1:0];
            quo_next = {quo_reg[VW-2:0], 1'b0};
        end else begin
            rem_next = diff_next[VW-1:0];
            quo_next = {quo_reg[VW-2:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (req.start) begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                cnt_reg  <= cnt_reg + 1'b1;
                // Drop busy and flag done after the last quotient bit
                busy_reg <= (cnt_reg != CW'(VW - 1));
                done_reg <= (cnt_reg == CW'(VW - 1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* sv/adc_sample_conditioner_unit.sv */
// Top level of the ADC sample conditioner: running-average filter and table calibration.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tuser kind, s_tdata sample or calibration point
//  m_*      out        m_tvalid / m_tready  m_tdata conditioned value
//  cfg_*    in         cfg_valid/cfg_ready  cfg_addr register index, cfg_data value
//
// One item at a time. A point write is taken in ST_IDLE and leaves the block
// idle. A sample runs the enabled steps in the configured order: the filter
// (ST_FILT_SUM, ST_FILT_MUL, ST_FILT_OUT) and the table scan (one memory read
// a cycle up to the upper segment point), then the 16-bit iterative slope
// division and the multiply. Reset (synchronous, active low) clears configuration,
// control and the previous filter output; the table holds whatever was
// written. A stalled result waits in the output register; the next item is
// accepted meanwhile and its result waits in ST_OUT until that slot frees.
module adc_sample_conditioner_unit #(
    parameter int TABLE_POINTS = 16,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0: sample, point_index, point_value, point_reading
    input  logic [((2*SAMPLE_BITS + $clog2(TABLE_POINTS) + asc_pkg::VAL_W + 7)/8)*8-1:0] s_tdata,
    // Field: opcode
    input  logic s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // Field: conditioned_value
    output logic [asc_pkg::VAL_W-1:0] m_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [asc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [asc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    localparam int VW    = asc_pkg::VAL_W;
    localparam int SB    = SAMPLE_BITS;
    localparam int IDX_W = $clog2(TABLE_POINTS);
    localparam int ENT_W = VW + SB;
    localparam int SW    = asc_pkg::FILT_SUM_W;
    localparam int PW    = asc_pkg::FILT_PROD_W;
    localparam int LPW   = 2 * VW;
    localparam int WW    = asc_pkg::WEIGHT_W;

    // Field offsets inside s_tdata
    localparam int OFS_IDX = SB;
    localparam int OFS_VAL = OFS_IDX + IDX_W;
    localparam int OFS_RD  = OFS_VAL + VW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_SUM,
        ST_FILT_MUL,
        ST_FILT_OUT,
        ST_SCAN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LIN_MUL,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic                         filt_en_reg;
    logic [WW-1:0]                weight_reg;
    logic                         lin_en_reg;
    logic                         lin_first_reg;
    logic [asc_pkg::COUNT_W-1:0]  count_reg;

    // Running value of the item and filter history
    logic [VW-1:0] x_reg;
    logic [VW-1:0] prev_reg;
    logic [SW-1:0] sum_reg;
    logic [PW-1:0] prod_reg;

    // Calibration table and scan
    logic [ENT_W-1:0] mem [TABLE_POINTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [ENT_W-1:0] lo_pt_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic             issue_reg;
    logic             eval_valid_reg;
    logic             below_reg;

    // Segment arithmetic
    logic [VW-1:0] dv_reg;
    logic [VW-1:0] dr_reg;
    logic [VW-1:0] ofs_reg;
    logic [VW-1:0] lo_val_reg;
    logic [VW-1:0] slope_reg;

    logic [VW-1:0] m_tdata_reg;
    logic          m_tvalid_reg;

    asc_pkg::div_req_t div_req;
    asc_pkg::div_rsp_t div_rsp;

    logic             s_xfer;
    logic             pt_wr;
    logic [IDX_W-1:0] pt_idx;
    logic [ENT_W-1:0] pt_ent;
    logic [IDX_W-1:0] last_idx_next;
    logic [WW-1:0]    weight_next;
    logic [SW-1:0]    sum_next;
    logic [VW-1:0]    filt_y_next;
    logic [LPW-1:0]   lin_prod_next;
    logic [VW-1:0]    rd_val;
    logic [VW-1:0]    rd_rdg;
    logic [VW-1:0]    lo_val;
    logic [VW-1:0]    lo_rdg;
    logic             hit;
    state_t           first_state;
    state_t           after_filt_state;
    state_t           after_lin_state;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Point writes land directly in the table; drop slots past the end
    assign pt_idx = s_tdata[OFS_IDX +: IDX_W];
    assign pt_ent = {s_tdata[OFS_RD +: SB], s_tdata[OFS_VAL +: VW]};
    assign pt_wr  = s_xfer && (s_tuser == asc_pkg::OP_POINT)
                    && (32'(pt_idx) < 32'(TABLE_POINTS));

    // Clamp the point count to the table and keep its last index
    always_comb begin
        if (count_reg < asc_pkg::COUNT_W'(2)) begin
            last_idx_next = IDX_W'(1);
        end else if (32'(count_reg) > 32'(TABLE_POINTS)) begin
            last_idx_next = IDX_W'(TABLE_POINTS - 1);
        end else begin
            last_idx_next = IDX_W'(32'(count_reg) - 32'd1);
        end
    end

    // Order of the two optional steps
    always_comb begin
        if (lin_first_reg) begin
            first_state = lin_en_reg ? ST_SCAN : (filt_en_reg ? ST_FILT_SUM : ST_OUT);
        end else begin
            first_state = filt_en_reg ? ST_FILT_SUM : (lin_en_reg ? ST_SCAN : ST_OUT);
        end
        after_filt_state = (!lin_first_reg && lin_en_reg) ? ST_SCAN : ST_OUT;
        after_lin_state  = (lin_first_reg && filt_en_reg) ? ST_FILT_SUM : ST_OUT;
    end

    // Filter datapath: weighted sum, reciprocal multiply, shift
    assign weight_next = (weight_reg > asc_pkg::FILT_DEN) ? asc_pkg::FILT_DEN : weight_reg;
    assign sum_next    = SW'(weight_next) * SW'(prev_reg)
                       + SW'(asc_pkg::FILT_DEN - weight_next) * SW'(x_reg);
    assign filt_y_next = prod_reg[asc_pkg::FILT_SHIFT +: VW];

    // Table entry fields
    assign rd_val = rd_data_reg[VW-1:0];
    assign rd_rdg = VW'(rd_data_reg[ENT_W-1:VW]);
    assign lo_val = lo_pt_reg[VW-1:0];
    assign lo_rdg = VW'(lo_pt_reg[ENT_W-1:VW]);
    assign hit    = rd_rdg > x_reg;

    assign lin_prod_next = LPW'(slope_reg) * LPW'(ofs_reg);

    assign div_req.start    = (state_reg == ST_DIV_GO);
    assign div_req.dividend = dv_reg;
    assign div_req.divisor  = dr_reg;

    asc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Calibration table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (pt_wr) begin
            mem[pt_idx] <= pt_ent;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            filt_en_reg    <= 1'b0;
            weight_reg     <= '0;
            lin_en_reg     <= 1'b0;
            lin_first_reg  <= 1'b0;
            count_reg      <= asc_pkg::COUNT_W'(2);
            prev_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            issue_reg      <= 1'b0;
            eval_valid_reg <= 1'b0;
        end else begin
            // Configuration transfers
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    asc_pkg::CFG_FILTER_ENABLE:   filt_en_reg   <= cfg_data[0];
                    asc_pkg::CFG_FILTER_WEIGHT:   weight_reg    <= cfg_data[WW-1:0];
                    asc_pkg::CFG_LINEAR_ENABLE:   lin_en_reg    <= cfg_data[0];
                    asc_pkg::CFG_LINEARIZE_FIRST: lin_first_reg <= cfg_data[0];
                    asc_pkg::CFG_POINT_COUNT:     count_reg     <= cfg_data;
                    default: ;
                endcase
            end

            // Release the output slot once taken; ST_OUT refills it itself
            if (m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    // Arm the table scan for whichever step runs it
                    addr_reg       <= '0;
                    issue_reg      <= 1'b1;
                    eval_valid_reg <= 1'b0;
                    if (s_xfer && (s_tuser == asc_pkg::OP_SAMPLE)) begin
                        x_reg        <= VW'(s_tdata[SB-1:0]);
                        last_idx_reg <= last_idx_next;
                        state_reg    <= first_state;
                    end
                end
                ST_FILT_SUM: begin
                    sum_reg   <= sum_next;
                    state_reg <= ST_FILT_MUL;
                end
                ST_FILT_MUL: begin
                    prod_reg  <= PW'(sum_reg) * PW'(asc_pkg::FILT_RECIP);
                    state_reg <= ST_FILT_OUT;
                end
                ST_FILT_OUT: begin
                    x_reg          <= filt_y_next;
                    prev_reg       <= filt_y_next;
                    addr_reg       <= '0;
                    issue_reg      <= 1'b1;
                    eval_valid_reg <= 1'b0;
                    state_reg      <= after_filt_state;
                end
                ST_SCAN: begin
                    // Issue one read a cycle, evaluate the entry read the cycle before;
                    // the scan is re-armed before every entry into this state
                    if (issue_reg) begin
                        if (addr_reg == last_idx_reg) begin
                            issue_reg <= 1'b0;
                        end else begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end
                    eval_valid_reg <= issue_reg;
                    eval_idx_reg   <= addr_reg;
                    if (eval_valid_reg) begin
                        if (eval_idx_reg == '0) begin
                            // Below the table: first segment wins
                            lo_pt_reg <= rd_data_reg;
                            below_reg <= hit;
                        end else if (below_reg || hit || (eval_idx_reg == last_idx_reg)) begin
                            dv_reg     <= rd_val - lo_val;
                            dr_reg     <= rd_rdg - lo_rdg;
                            ofs_reg    <= x_reg - lo_rdg;
                            lo_val_reg <= lo_val;
                            state_reg  <= ST_DIV_GO;
                        end else begin
                            lo_pt_reg <= rd_data_reg;
                        end
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        // Equal readings give a flat segment
                        slope_reg <= (dr_reg == '0) ? '0 : div_rsp.quotient;
                        state_reg <= ST_LIN_MUL;
                    end
                end
                ST_LIN_MUL: begin
                    x_reg     <= lin_prod_next[VW-1:0] + lo_val_reg;
                    state_reg <= after_lin_state;
                end
                ST_OUT: begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= x_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/adc_sample_conditioner_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the ADC sample conditioner: filter, table calibration, step order.
module adc_sample_conditioner_unit_test;

    // Block sizes, as built for this run
    localparam int TABLE_POINTS = 16;
    localparam int SAMPLE_BITS  = 10;
    localparam int INDEX_W      = $clog2(TABLE_POINTS);
    localparam int TDATA_W      = ((2*SAMPLE_BITS + INDEX_W + asc_pkg::VAL_W + 7)/8)*8;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int VALUE_MAX    = (1 << asc_pkg::VAL_W) - 1;

    // Filter weights are tenths; ten tenths keeps the previous output alone
    localparam int FILTER_FULL = 10;

    // Bit positions of the fields inside s_tdata
    localparam int IDX_LSB     = SAMPLE_BITS;
    localparam int VALUE_LSB   = IDX_LSB + INDEX_W;
    localparam int READING_LSB = VALUE_LSB + asc_pkg::VAL_W;

    // Run shaping
    localparam int SETTLE_CYCLES = 48;    // covers the longest sample
    localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer before giving up
    localparam int MAX_STALL     = 24;
    localparam int MAX_GAP       = 10;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 56;

    typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [TDATA_W-1:0]             s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [asc_pkg::VAL_W-1:0]      m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [asc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [asc_pkg::CFG_DATA_W-1:0] cfg_data;

    adc_sample_conditioner_unit #(
        .TABLE_POINTS(TABLE_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: own copy of configuration, filter memory and table
    // ------------------------------------------------------------------
    logic                          cfg_filter_en   = 1'b0;
    logic [asc_pkg::WEIGHT_W-1:0]  cfg_weight      = '0;
    logic                          cfg_linear_en   = 1'b0;
    logic                          cfg_lin_first   = 1'b0;
    logic [asc_pkg::COUNT_W-1:0]   cfg_point_count = asc_pkg::COUNT_W'(2);
    logic [asc_pkg::VAL_W-1:0]     prev_output     = '0;
    logic [asc_pkg::VAL_W-1:0]     cal_value   [TABLE_POINTS];
    logic [SAMPLE_BITS-1:0]        cal_reading [TABLE_POINTS];

    // Conditioned values still owed by the block, oldest first
    logic [asc_pkg::VAL_W-1:0] expected_values[$];

    int error_count     = 0;
    int results_checked = 0;
    int samples_seen    = 0;
    int points_seen     = 0;
    int cfg_writes      = 0;

    // Source and sink pacing, steered per phase by the tests
    int         burst_left    = 0;
    bit         steady_source = 1'b1;
    sink_mode_t sink_mode     = SINK_OPEN;

    // Weighted running average; updates the filter memory
    function automatic logic [asc_pkg::VAL_W-1:0] filter_sample(logic [asc_pkg::VAL_W-1:0] x);
        int unsigned w, y;
        w = (cfg_weight > FILTER_FULL) ? FILTER_FULL : 32'(cfg_weight);
        y = (w * prev_output + (FILTER_FULL - w) * x) / FILTER_FULL;
        prev_output = y[asc_pkg::VAL_W-1:0];
        return y[asc_pkg::VAL_W-1:0];
    endfunction

    // Piecewise-linear lookup with truncated integer slope, all differences mod 2^16
    function automatic logic [asc_pkg::VAL_W-1:0] calibrate_sample(
        logic [asc_pkg::VAL_W-1:0] x);
        int unsigned n, hi, dv, dr, slope, y;
        bit found;
        n = 32'(cfg_point_count);
        if (n < 2) n = 2;
        if (n > TABLE_POINTS) n = TABLE_POINTS;
        // Default to the last segment when no point in use lies above x
        hi = n - 1;
        found = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (!found && cal_reading[k] > x) begin
                // Below the table: stay on the first segment
                hi = (k == 0) ? 1 : k;
                found = 1'b1;
            end
        end
        dv = (32'(cal_value[hi]) - 32'(cal_value[hi-1])) & 32'hFFFF;
        dr = (32'(cal_reading[hi]) - 32'(cal_reading[hi-1])) & 32'hFFFF;
        slope = (dr == 0) ? 0 : dv / dr;
        y = slope * ((32'(x) - 32'(cal_reading[hi-1])) & 32'hFFFF) + 32'(cal_value[hi-1]);
        return y[asc_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [asc_pkg::VAL_W-1:0] condition_sample(
        logic [SAMPLE_BITS-1:0] raw);
        logic [asc_pkg::VAL_W-1:0] x;
        x = asc_pkg::VAL_W'(raw);
        if (cfg_lin_first) begin
            if (cfg_linear_en) x = calibrate_sample(x);
            if (cfg_filter_en) x = filter_sample(x);
        end else begin
            if (cfg_filter_en) x = filter_sample(x);
            if (cfg_linear_en) x = calibrate_sample(x);
        end
        return x;
    endfunction

    // Sample values biased toward the extremes and the table's break points
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned r;
        case ($urandom_range(0, 7))
            0: r = 0;
            1: r = SAMPLE_MAX;
            2, 3: begin
                r = cal_reading[$urandom_range(0, TABLE_POINTS-1)] + $urandom_range(0, 2);
                if (r > 0) r = r - 1;
                if (r > SAMPLE_MAX) r = SAMPLE_MAX;
            end
            default: r = $urandom_range(0, SAMPLE_MAX);
        endcase
        return r[SAMPLE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Count cycles in which no channel moves a transfer; give up at the limit
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles, %0d results still pending",
                 IDLE_LIMIT, expected_values.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink: stall the result channel on its own pattern, driven at the falling edge
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                case (sink_mode)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        // Long stalls now and then, open otherwise
                        if ($urandom_range(0, 5) == 0) begin
                            stall_left = $urandom_range(1, MAX_STALL - 1);
                            m_tready <= 1'b0;
                        end else begin
                            m_tready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted item, check every accepted result
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : bus_monitor
        logic [asc_pkg::VAL_W-1:0] want;
        if (aresetn) begin
            // Results first: a result landing with a new item belongs to an older one
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    $error("conditioned_value: expected nothing, actual %0d", m_tdata);
                    error_count++;
                end else begin
                    want = expected_values.pop_front();
                    results_checked++;
                    if (m_tdata !== want) begin
                        $error("conditioned_value: expected %0d, actual %0d", want, m_tdata);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == asc_pkg::OP_POINT) begin
                    // A point write updates the table and owes no result
                    points_seen++;
                    cal_value[s_tdata[IDX_LSB +: INDEX_W]] =
                        s_tdata[VALUE_LSB +: asc_pkg::VAL_W];
                    cal_reading[s_tdata[IDX_LSB +: INDEX_W]] =
                        s_tdata[READING_LSB +: SAMPLE_BITS];
                end else begin
                    samples_seen++;
                    expected_values.push_back(condition_sample(s_tdata[SAMPLE_BITS-1:0]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                case (cfg_addr)
                    asc_pkg::CFG_FILTER_ENABLE:   cfg_filter_en = cfg_data[0];
                    asc_pkg::CFG_FILTER_WEIGHT:   cfg_weight    = cfg_data[asc_pkg::WEIGHT_W-1:0];
                    asc_pkg::CFG_LINEAR_ENABLE:   cfg_linear_en = cfg_data[0];
                    asc_pkg::CFG_LINEARIZE_FIRST: cfg_lin_first = cfg_data[0];
                    asc_pkg::CFG_POINT_COUNT:
                        cfg_point_count = cfg_data[asc_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Present one item and hold it until the block takes it. Open a new burst,
    // with a random gap ahead of it unless steady_source is set, whenever the current one runs out.
    task automatic send_item(input logic kind, input logic [TDATA_W-1:0] payload);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady_source ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sample item; with noisy set, fill the unused point fields with junk
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw, input bit noisy);
        logic [TDATA_W-1:0] payload;
        payload = noisy ? TDATA_W'({$urandom, $urandom}) : '0;
        payload[SAMPLE_BITS-1:0] = raw;
        send_item(asc_pkg::OP_SAMPLE, payload);
    endtask

    task automatic send_point(input logic [INDEX_W-1:0] idx,
                              input logic [asc_pkg::VAL_W-1:0] value,
                              input logic [SAMPLE_BITS-1:0] reading, input bit noisy);
        logic [SAMPLE_BITS-1:0] junk;
        junk = noisy ? SAMPLE_BITS'($urandom) : '0;
        send_item(asc_pkg::OP_POINT, TDATA_W'({reading, value, idx, junk}));
    endtask

    // Drop valid, wait for every owed result, then let a point write finish too
    task automatic drain_and_settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [asc_pkg::CFG_ADDR_W-1:0] addr,
                                  input int unsigned value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value[asc_pkg::CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reprogram every register, only once the block has gone idle
    task automatic configure_conditioner(input bit filter_en, input int unsigned weight,
                                         input bit linear_en, input bit lin_first,
                                         input int unsigned count);
        drain_and_settle();
        write_register(asc_pkg::CFG_FILTER_ENABLE, 32'(filter_en));
        write_register(asc_pkg::CFG_FILTER_WEIGHT, weight);
        write_register(asc_pkg::CFG_LINEAR_ENABLE, 32'(linear_en));
        write_register(asc_pkg::CFG_LINEARIZE_FIRST, 32'(lin_first));
        write_register(asc_pkg::CFG_POINT_COUNT, count);
    endtask

    // Write the whole table with rising readings; repeat a reading now and then
    task automatic load_ascending_table();
        int unsigned rd, val;
        rd  = $urandom_range(0, 40);
        val = $urandom_range(0, 4000);
        for (int k = 0; k < TABLE_POINTS; k++) begin
            send_point(k[INDEX_W-1:0], val[asc_pkg::VAL_W-1:0], rd[SAMPLE_BITS-1:0], 1'b1);
            if ($urandom_range(0, 7) != 0) rd = rd + $urandom_range(1, 90);
            if (rd > SAMPLE_MAX) rd = SAMPLE_MAX;
            val = val + $urandom_range(0, 6000);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Both steps off: the raw reading comes straight through
    task automatic test_passthrough();
        sink_mode = SINK_OPEN;
        steady_source = 1'b1;
        configure_conditioner(1'b0, 0, 1'b0, 1'b0, 2);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
    endtask

    task automatic test_filter();
        sink_mode = SINK_CHOPPY;
        configure_conditioner(1'b1, 5, 1'b0, 1'b0, 2);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample('0, 1'b0);
        // Weight above ten acts as ten: the output holds the previous value
        configure_conditioner(1'b1, 15, 1'b0, 1'b0, 2);
        send_sample(SAMPLE_BITS'(100), 1'b0);
        // Weight zero follows the input alone
        configure_conditioner(1'b1, 0, 1'b0, 1'b0, 2);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        // With the filter off its memory must survive untouched
        configure_conditioner(1'b0, 5, 1'b0, 1'b0, 2);
        send_sample(SAMPLE_BITS'(7), 1'b0);
        configure_conditioner(1'b1, 5, 1'b0, 1'b0, 2);
        send_sample('0, 1'b0);
    endtask

    task automatic test_calibration();
        sink_mode = SINK_SLOW;
        configure_conditioner(1'b0, 0, 1'b0, 1'b0, 2);
        // Points 1 and 2 share a reading to give a flat segment
        send_point(INDEX_W'(0), asc_pkg::VAL_W'(1000), SAMPLE_BITS'(100), 1'b0);
        send_point(INDEX_W'(1), asc_pkg::VAL_W'(5000), SAMPLE_BITS'(300), 1'b0);
        send_point(INDEX_W'(2), asc_pkg::VAL_W'(6000), SAMPLE_BITS'(300), 1'b0);
        send_point(INDEX_W'(3), asc_pkg::VAL_W'(VALUE_MAX), SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        configure_conditioner(1'b0, 0, 1'b1, 1'b0, 4);
        send_sample(SAMPLE_BITS'(50), 1'b0);          // below the table, wraps
        send_sample(SAMPLE_BITS'(200), 1'b0);         // inside the first segment
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);  // at the top point: last segment
        send_sample('0, 1'b0);
        // Last segment is the flat pair: zero slope
        configure_conditioner(1'b0, 0, 1'b1, 1'b0, 3);
        send_sample(SAMPLE_BITS'(800), 1'b0);
        // Count below two clamps to two
        configure_conditioner(1'b0, 0, 1'b1, 1'b0, 0);
        send_sample(SAMPLE_BITS'(700), 1'b0);
    endtask

    task automatic test_step_order();
        sink_mode = SINK_CHOPPY;
        steady_source = 1'b0;
        configure_conditioner(1'b1, 3, 1'b1, 1'b1, 4);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_BITS'(10), 1'b0);
        configure_conditioner(1'b1, 3, 1'b1, 1'b0, 4);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_BITS'(10), 1'b0);
    endtask

    // Phases of fixed, then random settings; each runs mostly samples with stray point writes
    task automatic test_random_traffic();
        int unsigned weight, count;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: configure_conditioner(1'b1, FILTER_FULL, 1'b1, 1'b0, TABLE_POINTS);
                1: configure_conditioner(1'b1, 15, 1'b1, 1'b1, 31);
                2: configure_conditioner(1'b1, 0, 1'b1, 1'b0, 0);
                default: begin
                    weight = ($urandom_range(0, 2) == 0) ? $urandom_range(11, 15)
                                                         : $urandom_range(0, FILTER_FULL);
                    count  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                         : $urandom_range(2, TABLE_POINTS);
                    configure_conditioner(1'($urandom_range(0, 1)), weight,
                                          1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)), count);
                end
            endcase
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            steady_source = ($urandom_range(0, 3) == 0);
            // The first phase fills every slot before any wide lookup can touch it
            if (phase == 0 || $urandom_range(0, 2) == 0) load_ascending_table();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 5) == 0)
                    send_point(INDEX_W'($urandom), asc_pkg::VAL_W'($urandom),
                               SAMPLE_BITS'($urandom), 1'b1);
                else
                    send_sample(pick_sample(), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = asc_pkg::OP_SAMPLE;
        cfg_valid = 1'b0;
        cfg_addr  = asc_pkg::CFG_FILTER_ENABLE;
        cfg_data  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_passthrough();
        test_filter();
        test_calibration();
        test_step_order();
        test_random_traffic();
        drain_and_settle();

        if (expected_values.size() != 0) begin
            $error("conditioned_value: %0d expected results never arrived",
                   expected_values.size());
            error_count++;
        end
        $display("Run covered %0d samples and %0d calibration-point writes, %0d register writes,",
                 samples_seen, points_seen, cfg_writes);
        $display("with %0d conditioned values compared and %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
